// File: rtl/sosc_pkg.sv
// sosc_pkg: shared widths, register indexes, controller state and the
// command/status structs of the sine oscillator.
// No dependencies.
`default_nettype none

package sosc_pkg;

  localparam int FREQ_W     = 23;
  localparam int AMP_W      = 16;
  localparam int DC_W       = 16;
  localparam int SAMPLE_W   = 18;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECTIFY = 8'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_INC,
    S_ADVANCE,
    S_ROM,
    S_WAVE,
    S_MUL_AMP,
    S_SCALE
  } state_t;

  // One strobe per datapath step
  typedef struct packed {
    logic load;
    logic mul_inc;
    logic advance;
    logic rom_rd;
    logic wave;
    logic mul_amp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic chunk_last;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/sosc_ifs.sv
// sosc_ifs: valid/ready channel interfaces of the sine oscillator
// (input word, result word, configuration write). Depends on sosc_pkg.
`default_nettype none

interface sosc_in_if import sosc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     restart;
  logic [FREQ_W-1:0]        frequency;
  logic [AMP_W-1:0]         amplitude;
  logic signed [DC_W-1:0]   bias;

  modport source (output valid, restart, frequency, amplitude, bias, input ready);
  modport sink   (input valid, restart, frequency, amplitude, bias, output ready);
endinterface

interface sosc_out_if import sosc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface sosc_cfg_if import sosc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/sosc_ctrl.sv
// sosc_ctrl: controller state machine of the sine oscillator; sequences the
// datapath steps and owns both handshakes. Depends on sosc_pkg.
`default_nettype none

module sosc_ctrl import sosc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_MUL_INC;
      S_MUL_INC: if (sts.chunk_last) state_nxt = S_ADVANCE;
      S_ADVANCE: state_nxt = S_ROM;
      S_ROM:     state_nxt = S_WAVE;
      S_WAVE:    state_nxt = S_MUL_AMP;
      S_MUL_AMP: state_nxt = S_SCALE;
      S_SCALE:   if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MUL_INC: cmd.mul_inc  = 1'b1;
      S_ADVANCE: cmd.advance  = 1'b1;
      S_ROM:     cmd.rom_rd   = 1'b1;
      S_WAVE:    cmd.wave     = 1'b1;
      S_MUL_AMP: cmd.mul_amp  = 1'b1;
      S_SCALE:   cmd.out_load = slot_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // drop the word when taken, raise it on a new result
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/sosc_dp.sv
// sosc_dp: datapath of the sine oscillator: phase accumulator, shared
// multiplier, quarter-wave sine ROM, wave shaping, scaling and saturation.
// Depends on sosc_pkg; driven by the strobes of sosc_ctrl.
`default_nettype none

module sosc_dp import sosc_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int TABLE_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cmd_t                          cmd,
  output sts_t                               sts,
  input  wire logic                          in_restart,
  input  wire logic [FREQ_W-1:0]             in_frequency,
  input  wire logic [AMP_W-1:0]              in_amplitude,
  input  wire logic signed [DC_W-1:0]        in_bias,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  output logic signed [SAMPLE_W-1:0]         out_sample
);

  localparam int TAB_N   = 1 << TABLE_BITS;
  localparam int CHUNK_W = 25;
  localparam int MUL_W   = CHUNK_W + 1;
  localparam int RW      = PHASE_BITS - 7;
  localparam int RC      = (RW + CHUNK_W - 1) / CHUNK_W;
  localparam int CIW     = (RC > 1) ? $clog2(RC) : 1;
  localparam int ACC_W   = PHASE_BITS + 16;
  localparam int ADDR_W  = TABLE_BITS + 1;
  localparam int WAVE_W  = 17;
  localparam int PROD_W  = 34;
  localparam int SUM_W   = SAMPLE_W + 1;

  localparam logic [63:0] RECIP =
    ((64'd1 << (PHASE_BITS + 8)) + 64'd22050) / 64'd44100;
  localparam logic [RC*CHUNK_W-1:0] RECIP_PAD = (RC*CHUNK_W)'(RECIP);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef logic [14:0] tab_t [TAB_N+1];

  // sin(pi/2 * k / TAB_N) in Q15, Q2.30 Taylor series up to x^13
  function automatic logic [14:0] sine_q15(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    if (sum < 0) sum = '0;
    if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
    r = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return r[14:0];
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k <= TAB_N; k++) begin
      t[k] = sine_q15(k);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic                       restart_r;
  logic [FREQ_W-1:0]          freq_r;
  logic [AMP_W-1:0]           amp_r;
  logic signed [DC_W-1:0]     dc_r;
  logic                       invert_r;
  logic                       rectify_r;
  logic [CIW-1:0]             chunk_idx_r;
  logic [ACC_W-1:0]           acc_r;
  logic [PHASE_BITS-1:0]      phase_r;
  logic [14:0]                rom_q_r;
  logic                       neg_r;
  logic signed [WAVE_W-1:0]   wave_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] sample_r;

  logic [CHUNK_W-1:0]         chunk;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  mul_p;
  logic [ACC_W-1:0]           acc_rnd;
  logic [PHASE_BITS-1:0]      inc;
  logic [1:0]                 quad;
  logic [TABLE_BITS-1:0]      idx;
  logic [ADDR_W-1:0]          addr;
  logic signed [WAVE_W-1:0]   tab_s, base, wave_nxt;
  logic signed [PROD_W-1:0]   prod_rnd, scaled;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sat;

  assign sts.chunk_last = (chunk_idx_r == CIW'(RC - 1));
  assign chunk = RECIP_PAD[chunk_idx_r*CHUNK_W +: CHUNK_W];

  // shared multiplier: increment partial products, then amplitude gain
  always_comb begin
    if (cmd.mul_amp) begin
      mul_a = MUL_W'(wave_r);
      mul_b = $signed(MUL_W'(amp_r));
    end else begin
      mul_a = $signed(MUL_W'(freq_r));
      mul_b = $signed(MUL_W'(chunk));
    end
    mul_p = mul_a * mul_b;
  end

  assign acc_rnd = acc_r + ACC_W'(1 << 15);
  assign inc     = acc_rnd[ACC_W-1:16];

  assign quad = phase_r[PHASE_BITS-1 -: 2];
  assign idx  = phase_r[PHASE_BITS-3 -: TABLE_BITS];
  assign addr = quad[0] ? (ADDR_W'(TAB_N) - {1'b0, idx}) : {1'b0, idx};

  always_comb begin
    tab_s = $signed({2'b00, rom_q_r});
    if (rectify_r) begin
      base = (tab_s <<< 1) - 17'sd32768;
    end else begin
      base = neg_r ? -tab_s : tab_s;
    end
    wave_nxt = invert_r ? -base : base;
  end

  always_comb begin
    prod_rnd = prod_r + 34'sd16384;
    scaled   = prod_rnd >>> 15;
    sum      = scaled[SUM_W-1:0] + SUM_W'(dc_r);
    if (sum > 19'sd131071) begin
      sat = 18'sd131071;
    end else if (sum < -19'sd131072) begin
      sat = -18'sd131072;
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r  <= 1'b0;
      rectify_r <= 1'b0;
      phase_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_INVERT) invert_r <= cfg_data[0];
      if (cfg_we && cfg_index == CFG_RECTIFY) rectify_r <= cfg_data[0];
      if (cmd.advance) phase_r <= (restart_r ? '0 : phase_r) + inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      restart_r   <= in_restart;
      freq_r      <= in_frequency;
      amp_r       <= in_amplitude;
      dc_r        <= in_bias;
      acc_r       <= '0;
      chunk_idx_r <= '0;
    end
    if (cmd.mul_inc) begin
      acc_r       <= acc_r + (ACC_W'(mul_p[2*CHUNK_W-1:0]) << (CHUNK_W * chunk_idx_r));
      chunk_idx_r <= chunk_idx_r + CIW'(1);
    end
    if (cmd.rom_rd) begin
      rom_q_r <= SINE_TAB[addr];
      neg_r   <= quad[1];
    end
    if (cmd.wave) wave_r <= wave_nxt;
    if (cmd.mul_amp) prod_r <= mul_p[PROD_W-1:0];
    if (cmd.out_load) sample_r <= sat;
  end

  assign out_sample = sample_r;

endmodule

`default_nettype wire

// File: rtl/sine_oscillator.sv
// sine_oscillator: phase-accumulator sine oscillator, one output word per
// input word. Instantiates sosc_ctrl and sosc_dp; depends on sosc_pkg, sosc_ifs.
//
// Usage:
//   in_ch  : one word per sample tick (restart, frequency Q15.8 Hz,
//            amplitude Q1.15, bias Q1.15). Restart clears the phase
//            before that tick's advance.
//   out_ch : one signed Q3.15 sample per input word, saturated.
//   cfg_ch : register writes (index 0 invert_output, 1 rectify); always
//            ready, write only while no word is in flight. Other indexes
//            are ignored.
// Sequence: each word takes RC passes of the single shared multiplier for
//   the phase increment, RC = ceil((PHASE_BITS - 7) / 25) (RC = 1 up to
//   PHASE_BITS = 32), then the phase advance, one ROM read, the shaping,
//   one gain multiply and the output step. A new word is accepted only
//   after the previous one has passed the output step, which registers out_valid.
// Reset (rst_n low, synchronous) clears phase, both registers and the
//   output valid. A stalled receiver holds the result word in the output
//   register; the next input word is still accepted and worked up to the
//   final step, which waits for the output register to free up.
`default_nettype none

module sine_oscillator import sosc_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int TABLE_BITS = 10
) (
  input wire logic   clk,
  input wire logic   rst_n,
  sosc_in_if.sink    in_ch,
  sosc_out_if.source out_ch,
  sosc_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  sosc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sosc_dp #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_restart   (in_ch.restart),
    .in_frequency (in_ch.frequency),
    .in_amplitude (in_ch.amplitude),
    .in_bias      (in_ch.bias),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_sample   (out_ch.sample)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten while stalled");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.out_load))
    else $error("output valid raised without a result load");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul_inc, cmd.advance, cmd.rom_rd,
              cmd.wave, cmd.mul_amp, cmd.out_load}))
    else $error("more than one datapath step at once");

endmodule

`default_nettype wire

// File: verif/sine_oscillator_test.sv
// sine_oscillator_test: self-checking bench for the phase-accumulator sine oscillator.
// Depends on sosc_pkg, the channel interfaces in sosc_ifs and the sine_oscillator RTL.
// Checks every sample against a bit-true predictor of the phase, table and scaling math.
`default_nettype none

module sine_oscillator_test import sosc_pkg::*; ();

  localparam int PHASE_BITS = 32;
  localparam int TABLE_BITS = 10;
  localparam int TAB_N = 1 << TABLE_BITS;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PHASE_RECIP = ((64'd1 << (PHASE_BITS + 8)) + 64'd22050) / 64'd44100;

  localparam longint SAT_HI = 131071;
  localparam longint SAT_LO = -131072;

  localparam int unsigned FREQ_QUARTER = 2822400;  // 11025 Hz: a quarter cycle per tick
  localparam int unsigned FREQ_NYQUIST = 5644800;
  localparam int unsigned FREQ_FIELD_MAX = 8388607;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd7;

  localparam int N_PHASES = 5;
  localparam bit [N_PHASES-1:0] INV_BY_PHASE = 5'b01010;
  localparam bit [N_PHASES-1:0] RECT_BY_PHASE = 5'b01100;
  localparam int RANDOM_PER_PHASE = 265;

  localparam int HOLD_AT_WORD = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic restart;
    logic [FREQ_W-1:0] frequency;
    logic [AMP_W-1:0] amplitude;
    logic signed [DC_W-1:0] bias;
  } tick_t;

  class sine_scoreboard;
    int unsigned quarter_rom[TAB_N + 1];
    logic [PHASE_BITS-1:0] phase_acc;
    logic invert;
    logic rectify;
    logic signed [SAMPLE_W-1:0] pending[$];
    int errors;

    function new();
      longint unsigned x, x2, term;
      longint sum;
      for (int k = 0; k <= TAB_N; k++) begin
        x = (HALF_PI_Q30 * longint'(k)) >> TABLE_BITS;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        // Taylor series of sin up to x^13
        for (int n = 1; n <= 6; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum -= longint'(term);
          else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
        quarter_rom[k] = int'((longint'(sum) * 32767 + (64'd1 << 29)) >> 30);
      end
      phase_acc = '0;
      invert = 1'b0;
      rectify = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_INVERT: invert = d[0];
        CFG_RECTIFY: rectify = d[0];
        default: ;
      endcase
    endfunction

    function void note_word(tick_t t);
      longint unsigned inc;
      logic [1:0] quad;
      logic [TABLE_BITS-1:0] idx;
      longint wave, mag, res;
      if (t.restart) phase_acc = '0;
      inc = (longint'(t.frequency) * PHASE_RECIP + (64'd1 << 15)) >> 16;
      phase_acc = phase_acc + inc[PHASE_BITS-1:0];
      quad = phase_acc[PHASE_BITS-1 -: 2];
      idx = phase_acc[PHASE_BITS-3 -: TABLE_BITS];
      wave = quad[0] ? longint'(quarter_rom[TAB_N - idx]) : longint'(quarter_rom[idx]);
      if (quad[1]) wave = -wave;
      if (rectify) begin
        mag = (wave < 0) ? -wave : wave;
        wave = 2 * mag - 32768;
      end
      if (invert) wave = -wave;
      // round half up, floor division by 2^15
      res = ((wave * longint'(t.amplitude) + 16384) >>> 15) + longint'(t.bias);
      if (res > SAT_HI) res = SAT_HI;
      if (res < SAT_LO) res = SAT_LO;
      pending.push_back(res[SAMPLE_W-1:0]);
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $time, what);
      errors++;
    endtask

    task check_sample(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("sample %0d with no word outstanding", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) report($sformatf("sample %0d, expected %0d", got, want));
    endtask
  endclass

  logic clk;
  logic rst_n;

  sosc_in_if in_ch();
  sosc_out_if out_ch();
  sosc_cfg_if cfg_ch();

  sine_oscillator #(
    .PHASE_BITS(PHASE_BITS),
    .TABLE_BITS(TABLE_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  sine_scoreboard sb = new();
  bit in_fast;
  bit out_fast;
  int n_out;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic tick_t mk_tick(bit r, int unsigned f, int unsigned a, int d);
    tick_t t;
    t.restart = r;
    t.frequency = f[FREQ_W-1:0];
    t.amplitude = a[AMP_W-1:0];
    t.bias = d[DC_W-1:0];
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int unsigned fsel, asel, dsel;
    fsel = $urandom_range(0, 9);
    asel = $urandom_range(0, 7);
    dsel = $urandom_range(0, 7);
    t.restart = ($urandom_range(0, 15) == 0);
    case (fsel)
      6: t.frequency = FREQ_W'($urandom_range(0, 2560));
      7: t.frequency = FREQ_W'($urandom());
      8: t.frequency = FREQ_W'(FREQ_NYQUIST - $urandom_range(0, 64));
      9: t.frequency = FREQ_W'(FREQ_QUARTER + $urandom_range(0, 64) - 32);
      default: t.frequency = FREQ_W'($urandom_range(0, FREQ_NYQUIST));
    endcase
    case (asel)
      0: t.amplitude = '1;
      1: t.amplitude = '0;
      default: t.amplitude = AMP_W'($urandom());
    endcase
    case (dsel)
      0: t.bias = 16'sh7fff;
      1: t.bias = 16'sh8000;
      default: t.bias = DC_W'($urandom());
    endcase
    return t;
  endfunction

  // Call at a falling edge; returns at the falling edge after the word is taken,
  // with valid still high.
  task automatic send_tick(tick_t t);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= t.restart;
    in_ch.frequency <= t.frequency;
    in_ch.amplitude <= t.amplitude;
    in_ch.bias <= t.bias;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(t);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic program_regs(bit inv, bit rect, bit poke_unused);
    write_reg(CFG_INVERT, inv);
    write_reg(CFG_RECTIFY, rect);
    if (poke_unused) write_reg(CFG_UNUSED, 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    n_out = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (n_out % 40 == 0) out_fast = ($urandom_range(0, 3) == 0);
      if (n_out == HOLD_AT_WORD) stall = HOLD_CYCLES;
      else stall = out_fast ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_sample(out_ch.sample);
      n_out++;
      @(negedge clk);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    in_ch.frequency = '0;
    in_ch.amplitude = '0;
    in_ch.bias = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    idle_cycles = 0;
    in_fast = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      program_regs(INV_BY_PHASE[ph], RECT_BY_PHASE[ph], ph == 2);
      if (ph == 0) begin
        send_tick(mk_tick(1, 0, 32768, 0));
        send_tick(mk_tick(1, FREQ_NYQUIST, 65535, 32767));
        send_tick(mk_tick(0, FREQ_NYQUIST, 65535, -32768));
        send_tick(mk_tick(1, FREQ_FIELD_MAX, 0, 32767));
        send_tick(mk_tick(0, FREQ_FIELD_MAX, 0, -32768));
        send_tick(mk_tick(0, 1, 1, 0));
        send_tick(mk_tick(0, 0, 65535, -1));
        send_tick(mk_tick(1, 256, 32768, 0));
      end
      // step through the quadrants from a fresh phase
      send_tick(mk_tick(1, FREQ_QUARTER, 65535, 0));
      repeat (4) send_tick(mk_tick(0, FREQ_QUARTER, 65535, 0));
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i % 40 == 0) in_fast = ($urandom_range(0, 3) == 0);
        send_tick(random_tick());
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
